@@ rtl/yolo_box_decode_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the box decode unit
// Shared concurrent assertion forms, removable as a group with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef YOLO_BOX_DECODE_UNIT_DEFINES_SVH
`define YOLO_BOX_DECODE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Condition and consequence in the same cycle.
`define YBD_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ybd assertion failed");
// Consequence in the cycle after the condition.
`define YBD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ybd assertion failed");
`else
`define YBD_ASSERT_SAME(label, clk, rst, pre, post)
`define YBD_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

@@ rtl/ybd_pkg.sv @@
// ---------------------------------------------------------------------------
// Box decode package
// Types, constants and the sigmoid breakpoint table of the box decode unit.
// ---------------------------------------------------------------------------
package ybd_pkg;

   // Default number of detection stages.
   localparam int STAGE_COUNT = 3;

   // Output range of a Q13.8 result.
   localparam logic signed [21:0] OUT_MAX = 22'sh1FFFFF;
   localparam logic signed [21:0] OUT_MIN = -22'sh200000;

   // How a channel is decoded.
   typedef enum logic [1:0] {
      KIND_XY,
      KIND_WH,
      KIND_SCORE
   } kind_type;

   // Item fields that ride along with the sigmoid.
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         stride;
      logic signed [16:0] grid;
      logic [17:0]        anchor;
   } side_type;

   // Reset stride of a stage: 8, 16, 32.
   function automatic logic [7:0] stride_reset(input int idx);
      logic [7:0] val;
      val = 8'd8 << idx;
      return val;
   endfunction

   // round(65536*sigmoid(k/2)), last breakpoint held at 65535.
   function automatic logic [15:0] sig_lut(input logic [4:0] k);
      logic [15:0] val;
      unique case (k)
         5'd0:    val = 16'd32768;
         5'd1:    val = 16'd40793;
         5'd2:    val = 16'd47911;
         5'd3:    val = 16'd53581;
         5'd4:    val = 16'd57724;
         5'd5:    val = 16'd60565;
         5'd6:    val = 16'd62428;
         5'd7:    val = 16'd63615;
         5'd8:    val = 16'd64357;
         5'd9:    val = 16'd64816;
         5'd10:   val = 16'd65097;
         5'd11:   val = 16'd65269;
         5'd12:   val = 16'd65374;
         5'd13:   val = 16'd65438;
         5'd14:   val = 16'd65476;
         5'd15:   val = 16'd65500;
         default: val = 16'd65535;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/ybd_sigmoid.sv @@
// ---------------------------------------------------------------------------
// Sigmoid pipeline
// Two stages: table lookup of the breakpoints, then interpolation and sign.
// ---------------------------------------------------------------------------
`include "yolo_box_decode_unit_defines.svh"

module ybd_sigmoid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [15:0]    in_logit,
   input  ybd_pkg::side_type     in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [15:0]           out_sig,
   output ybd_pkg::side_type     out_side
);

   logic              a_valid_ff;
   logic [15:0]       a_lo_ff,   a_lo_in;
   logic [15:0]       a_diff_ff, a_diff_in;
   logic [6:0]        a_frac_ff;
   logic              a_neg_ff;
   logic              a_sat_ff;
   ybd_pkg::side_type a_side_ff;
   logic              b_valid_ff;
   logic [15:0]       s_ff, s_in;
   ybd_pkg::side_type b_side_ff;

   logic        a_en, b_en;
   logic [16:0] mag;
   logic [4:0]  idx;
   logic [22:0] slope;
   logic [23:0] slope_rnd;
   logic [16:0] p;
   logic [16:0] p_neg;

   // Each stage moves when it is empty or its successor moves.
   assign b_en     = !b_valid_ff || out_ready;
   assign a_en     = !a_valid_ff || b_en;
   assign in_ready = a_en;

   // Stage A: magnitude, segment index and breakpoint lookup.
   always_comb begin
      mag       = in_logit[15] ? (17'd0 - {in_logit[15], in_logit})
                               : {in_logit[15], in_logit};
      idx       = {1'b0, mag[10:7]};
      a_lo_in   = ybd_pkg::sig_lut(idx);
      a_diff_in = ybd_pkg::sig_lut(idx + 5'd1) - a_lo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= in_valid;
      end
      if (a_en) begin
         a_lo_ff   <= a_lo_in;
         a_diff_ff <= a_diff_in;
         a_frac_ff <= mag[6:0];
         a_neg_ff  <= in_logit[15];
         a_sat_ff  <= |mag[16:11];
         a_side_ff <= in_side;
      end
   end

   // Stage B: linear interpolation, mirror for negative inputs, saturation.
   always_comb begin
      slope     = {7'd0, a_diff_ff} * {16'd0, a_frac_ff};
      slope_rnd = {1'b0, slope} + 24'd64;
      p         = {1'b0, a_lo_ff} + slope_rnd[23:7];
      p_neg     = 17'h10000 - p;
      if (a_sat_ff) begin
         s_in = a_neg_ff ? 16'h0000 : 16'hFFFF;
      end else begin
         s_in = a_neg_ff ? p_neg[15:0] : p[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_en) begin
         s_ff      <= s_in;
         b_side_ff <= a_side_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_sig   = s_ff;
   assign out_side  = b_side_ff;

   // A large positive logit saturates to the top code.
   `YBD_ASSERT_NEXT(a_sat_pos, clock, reset,
                    a_valid_ff && a_sat_ff && !a_neg_ff && b_en, s_ff == 16'hFFFF)
   // Non-negative logits land in the upper half.
   `YBD_ASSERT_NEXT(a_upper_half, clock, reset,
                    a_valid_ff && !a_neg_ff && b_en, s_ff >= 16'h8000)
   // Negative logits land in the lower half.
   `YBD_ASSERT_NEXT(a_lower_half, clock, reset,
                    a_valid_ff && a_neg_ff && b_en, s_ff <= 16'h8000)

endmodule

@@ rtl/ybd_scale.sv @@
// ---------------------------------------------------------------------------
// Scale pipeline
// Two stages: first products per channel kind, then anchor product,
// rounding to Q13.8 and saturation into the output register.
// ---------------------------------------------------------------------------
`include "yolo_box_decode_unit_defines.svh"

module ybd_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [15:0]           in_sig,
   input  ybd_pkg::side_type     in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [21:0]    out_value
);

   logic               c_valid_ff;
   ybd_pkg::kind_type  c_kind_ff;
   logic signed [34:0] c_xy_ff, c_xy_in;
   logic [33:0]        c_tt_ff, c_tt_in;
   logic [17:0]        c_anchor_ff;
   logic [8:0]         c_score_ff, c_score_in;
   logic               d_valid_ff;
   logic signed [21:0] value_ff, value_in;

   logic               c_en, d_en;
   logic signed [25:0] ctr;
   logic [16:0]        twice;
   logic [16:0]        score_sum;
   logic signed [35:0] xy_sum;
   logic signed [27:0] xy_q8;
   logic [51:0]        wh_prod;
   logic [52:0]        wh_sum;

   assign d_en     = !d_valid_ff || out_ready;
   assign c_en     = !c_valid_ff || d_en;
   assign in_ready = c_en;

   // Stage C: (2s + grid) * stride, (2s)^2, and the rounded score.
   always_comb begin
      twice      = {in_sig, 1'b0};
      ctr        = $signed({in_side.grid[16], in_side.grid, 8'd0}) +
                   $signed({9'd0, twice});
      c_xy_in    = 35'(ctr) * 35'($signed({1'b0, in_side.stride}));
      c_tt_in    = {17'd0, twice} * {17'd0, twice};
      score_sum  = {1'b0, in_sig} + 17'd128;
      c_score_in = score_sum[16:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_en) begin
         c_valid_ff <= in_valid;
      end
      if (c_en) begin
         c_kind_ff   <= in_side.kind;
         c_xy_ff     <= c_xy_in;
         c_tt_ff     <= c_tt_in;
         c_anchor_ff <= in_side.anchor;
         c_score_ff  <= c_score_in;
      end
   end

   // Stage D: round to Q13.8 and saturate. The anchor product cannot exceed
   // the positive limit after the shift, so it needs no clamp.
   always_comb begin
      xy_sum  = {c_xy_ff[34], c_xy_ff} + 36'sd128;
      xy_q8   = xy_sum[35:8];
      wh_prod = {18'd0, c_tt_ff} * {34'd0, c_anchor_ff};
      wh_sum  = {1'b0, wh_prod} + 53'h0_0000_8000_0000;
      unique case (c_kind_ff)
         ybd_pkg::KIND_XY: begin
            if (xy_q8 > 28'(ybd_pkg::OUT_MAX)) begin
               value_in = ybd_pkg::OUT_MAX;
            end else if (xy_q8 < 28'(ybd_pkg::OUT_MIN)) begin
               value_in = ybd_pkg::OUT_MIN;
            end else begin
               value_in = xy_q8[21:0];
            end
         end
         ybd_pkg::KIND_WH: begin
            value_in = {1'b0, wh_sum[52:32]};
         end
         ybd_pkg::KIND_SCORE: begin
            value_in = {13'd0, c_score_ff};
         end
         default: begin
            value_in = {13'd0, c_score_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_en) begin
         d_valid_ff <= c_valid_ff;
      end
      if (d_en) begin
         value_ff <= value_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_value = value_ff;

   // A score result is a probability between 0 and 1.0 in Q13.8.
   `YBD_ASSERT_NEXT(a_score_range, clock, reset,
                    c_valid_ff && d_en && c_kind_ff == ybd_pkg::KIND_SCORE,
                    !value_ff[21] && value_ff <= 22'sd256)
   // A box size is never negative.
   `YBD_ASSERT_NEXT(a_size_sign, clock, reset,
                    c_valid_ff && d_en && c_kind_ff == ybd_pkg::KIND_WH,
                    !value_ff[21])
   // The output stage takes the valid bit of stage C whenever it moves.
   `YBD_ASSERT_NEXT(a_valid_moves, clock, reset, d_en, d_valid_ff == $past(c_valid_ff))

endmodule

@@ rtl/yolo_box_decode_unit.sv @@
// ---------------------------------------------------------------------------
// YOLO box decode unit
// Detect-head element decode: sigmoid, then box center, box size or score.
// ---------------------------------------------------------------------------
// The unit takes one head logit per word and returns one Q13.8 value per
// word, in order. It accepts a new word every clock cycle unless a stalled
// output has filled the pipeline. Each word passes through registered stages
// in order: input decode and table lookup, sigmoid interpolation, first
// products, and anchor product with rounding into the output register.
// Stages that hold no word fill up while the output is stalled, so the
// input stays ready until the pipeline is full. Stride registers are
// written through the csr port, one per stage, and should only change
// while no word is in flight.
`include "yolo_box_decode_unit_defines.svh"

module yolo_box_decode_unit #(
   parameter int STAGE_COUNT = ybd_pkg::STAGE_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   // tdata, low bit up: logit[15:0], grid_offset[32:16],
   // anchor_size[50:33], zero pad[55:51]
   input  logic [55:0] req_tdata,
   // tuser, low bit up: channel[6:0], stage[8:7]
   input  logic [8:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata, low bit up: value[21:0], zero pad[23:22]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam int SEL_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

   logic [7:0] stride_ff [STAGE_COUNT];

   logic signed [15:0] logit;
   logic [6:0]         channel;
   logic [1:0]         stage;
   logic [1:0]         stage_sel;
   ybd_pkg::side_type  side;
   logic               sig_valid, sig_ready;
   logic [15:0]        sig_val;
   ybd_pkg::side_type  sig_side;
   logic signed [21:0] value;

   // Stride registers, one per stage; writes past the last stage are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGE_COUNT; i++) begin
            stride_ff[i] <= ybd_pkg::stride_reset(i);
         end
      end else if (csr_valid && ({1'b0, csr_index} < 3'(STAGE_COUNT))) begin
         stride_ff[csr_index[SEL_W-1:0]] <= csr_data;
      end
   end

   // Unpack the word, classify the channel and pick the stride.
   always_comb begin
      logit     = $signed(req_tdata[15:0]);
      channel   = req_tuser[6:0];
      stage     = req_tuser[8:7];
      stage_sel = ({1'b0, stage} >= 3'(STAGE_COUNT)) ? 2'(STAGE_COUNT - 1) : stage;
      if (channel < 7'd2) begin
         side.kind = ybd_pkg::KIND_XY;
      end else if (channel < 7'd4) begin
         side.kind = ybd_pkg::KIND_WH;
      end else begin
         side.kind = ybd_pkg::KIND_SCORE;
      end
      side.stride = stride_ff[stage_sel[SEL_W-1:0]];
      side.grid   = $signed(req_tdata[32:16]);
      side.anchor = req_tdata[50:33];
   end

   ybd_sigmoid u_sigmoid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_logit  (logit),
      .in_side   (side),
      .out_valid (sig_valid),
      .out_ready (sig_ready),
      .out_sig   (sig_val),
      .out_side  (sig_side)
   );

   ybd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sig_valid),
      .in_ready  (sig_ready),
      .in_sig    (sig_val),
      .in_side   (sig_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (value)
   );

   assign rsp_tdata = {2'b00, value};

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Box decode unit testbench
// Drives head logits through the decode unit and compares every decoded
// value with a hand-typed value or a cycle-free model of the sigmoid and
// the box and score decode. A short table of directed words comes first.
// Three randomized phases follow, each with its own stride settings and
// its own pattern of source gaps and sink stalls.
// ---------------------------------------------------------------------------
module tb_top;

   // Register indexes of the csr port.
   localparam logic [1:0] REG_STRIDE_SMALL  = 2'd0;
   localparam logic [1:0] REG_STRIDE_MEDIUM = 2'd1;
   localparam logic [1:0] REG_STRIDE_LARGE  = 2'd2;
   localparam logic [1:0] REG_UNUSED        = 2'd3;

   // Cycles to let pass after the last result before touching the registers.
   localparam int DRAIN_SLACK = 8;

   // Sigmoid breakpoints, round(65536*sigmoid(k/2)), last one held at 65535.
   localparam longint SIG_KNOTS [17] = '{
      32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
      64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65535
   };

   // Data part of a request word, laid out exactly as req_tdata.
   typedef struct packed {
      logic [4:0]         zero_pad;
      logic [17:0]        anchor;
      logic signed [16:0] grid;
      logic signed [15:0] logit;
   } head_data_type;

   // Side part of a request word, laid out exactly as req_tuser.
   typedef struct packed {
      logic [1:0]         stage;
      logic [6:0]         channel;
   } head_user_type;

   // A directed word, with its decoded value where it is known by hand.
   typedef struct packed {
      logic signed [15:0] logit;
      logic [6:0]         channel;
      logic [1:0]         stage;
      logic signed [16:0] grid;
      logic [17:0]        anchor;
      logic               pinned;
      logic signed [21:0] value;
   } directed_row_type;

   // Directed words, decoded with the reset strides 8, 16 and 32.
   localparam directed_row_type DIRECTED_ROWS [21] = '{
      // Sigmoid midpoint as a score.
      '{16'sd0, 7'd4, 2'd0, 17'sd0, 18'd0, 1'b1, 22'sd128},
      // Largest and smallest logit.
      '{16'sh7FFF, 7'd4, 2'd0, 17'sd0, 18'd0, 1'b1, 22'sd256},
      '{16'sh8000, 7'd4, 2'd0, 17'sd0, 18'd0, 1'b1, 22'sd0},
      // Magnitude of exactly 8.0 saturates the sigmoid.
      '{16'sd2048, 7'd5, 2'd1, 17'sd0, 18'd0, 1'b1, 22'sd256},
      '{-16'sd2048, 7'd84, 2'd2, 17'sd0, 18'd0, 1'b1, 22'sd0},
      // Just inside the table.
      '{16'sd2047, 7'd84, 2'd0, 17'sd0, 18'd0, 1'b0, 22'sd0},
      '{-16'sd2047, 7'd4, 2'd0, 17'sd0, 18'd0, 1'b0, 22'sd0},
      // Channel past the last class is still a score.
      '{16'sd0, 7'd127, 2'd3, 17'sd0, 18'd0, 1'b1, 22'sd128},
      // Box center at grid zero, then with the stage out of range.
      '{16'sd0, 7'd0, 2'd0, 17'sd0, 18'd0, 1'b1, 22'sd2048},
      '{16'sd0, 7'd1, 2'd3, 17'sd0, 18'd0, 1'b1, 22'sd8192},
      // Box center saturates at the top of the output range.
      '{16'sh7FFF, 7'd0, 2'd2, 17'sd65535, 18'd0, 1'b1, ybd_pkg::OUT_MAX},
      // Grid offset of -1.0 with the sigmoid at zero.
      '{16'sh8000, 7'd1, 2'd0, -17'sd256, 18'd0, 1'b1, -22'sd2048},
      '{16'sd300, 7'd0, 2'd1, 17'sd1234, 18'd0, 1'b0, 22'sd0},
      '{-16'sd1000, 7'd1, 2'd2, -17'sd100, 18'd0, 1'b0, 22'sd0},
      // Box size: midpoint sigmoid with a one-pixel anchor, then extremes.
      '{16'sd0, 7'd3, 2'd0, 17'sd0, 18'd256, 1'b1, 22'sd256},
      '{16'sh7FFF, 7'd2, 2'd0, 17'sd0, 18'h3FFFF, 1'b0, 22'sd0},
      '{-16'sd500, 7'd2, 2'd1, 17'sd0, 18'd100000, 1'b0, 22'sd0},
      '{16'sd777, 7'd3, 2'd2, 17'sd0, 18'd0, 1'b1, 22'sd0},
      // All-ones grid and anchor fields on a center channel.
      '{16'sd128, 7'd0, 2'd1, 17'sh1FFFF, 18'h3FFFF, 1'b0, 22'sd0},
      // Most negative grid field.
      '{16'sd1, 7'd0, 2'd2, 17'sh10000, 18'd0, 1'b0, 22'sd0},
      // Unused fields fully set on a score channel.
      '{-16'sd1, 7'd64, 2'd3, 17'sh1FFFF, 18'h3FFFF, 1'b0, 22'sd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [55:0] req_tdata = '0;
   logic [8:0]  req_tuser = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   // Hand-typed value that travels with the word on the request bus.
   logic               pinned_valid = 1'b0;
   logic signed [21:0] pinned_value = '0;

   // Model copy of the stride registers and the values still owed by the unit.
   logic [7:0]         stride_regs [3];
   logic signed [21:0] pending_values [$];
   int                 fail_count = 0;

   // Gap and stall rates in percent.
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   yolo_box_decode_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Decodes one word: sigmoid of the logit, then center, size or score.
   function automatic logic signed [21:0] decode_value(input head_data_type d,
                                                       input head_user_type u);
      longint            logit_v;
      longint            mag;
      longint            sig;
      longint            interp;
      longint            product;
      longint            result;
      longint unsigned   twice_sig;
      longint unsigned   area;
      int                stage_sel;
      ybd_pkg::kind_type kind;
      logit_v = $signed(d.logit);
      mag = (logit_v < 0) ? -logit_v : logit_v;
      // Saturate at 8.0, otherwise interpolate between half-unit breakpoints.
      if (mag >= 2048) begin
         sig = (logit_v < 0) ? 0 : 65535;
      end else begin
         interp = SIG_KNOTS[mag >> 7]
                + (((SIG_KNOTS[(mag >> 7) + 1] - SIG_KNOTS[mag >> 7]) * (mag & 127) + 64)
                   >> 7);
         sig = (logit_v < 0) ? 65536 - interp : interp;
      end
      stage_sel = int'(u.stage);
      if (stage_sel >= ybd_pkg::STAGE_COUNT) begin
         stage_sel = ybd_pkg::STAGE_COUNT - 1;
      end
      if (u.channel < 7'd2) begin
         kind = ybd_pkg::KIND_XY;
      end else if (u.channel < 7'd4) begin
         kind = ybd_pkg::KIND_WH;
      end else begin
         kind = ybd_pkg::KIND_SCORE;
      end
      case (kind)
         ybd_pkg::KIND_XY: begin
            // (2s + grid) in Q.16 times the stride, rounded half up to Q.8.
            product = (2 * sig + longint'($signed(d.grid)) * 256)
                    * longint'(stride_regs[stage_sel]);
            result = (product + 128) >>> 8;
         end
         ybd_pkg::KIND_WH: begin
            // (2s)^2 in Q.32 times the Q.8 anchor, rounded back to Q.8.
            twice_sig = longint'(2 * sig);
            area = twice_sig * twice_sig * d.anchor;
            area = (area + (64'd1 << 31)) >> 32;
            result = longint'(area);
         end
         default: begin
            result = (sig + 128) >> 8;
         end
      endcase
      if (result > longint'(ybd_pkg::OUT_MAX)) begin
         result = longint'(ybd_pkg::OUT_MAX);
      end else if (result < longint'(ybd_pkg::OUT_MIN)) begin
         result = longint'(ybd_pkg::OUT_MIN);
      end
      return 22'(result);
   endfunction

   // Sink: random stalls at the current rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (int'($urandom_range(99)) >= rsp_stall_pct);
      end
   end

   // Tracks register writes and accepted words, and checks each result word.
   always @(posedge clock) begin
      logic signed [21:0] want;
      logic signed [21:0] got;
      if (reset) begin
         stride_regs[0] = 8'd8;
         stride_regs[1] = 8'd16;
         stride_regs[2] = 8'd32;
         pending_values.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index != REG_UNUSED) begin
            stride_regs[csr_index] = csr_data;
         end
         if (req_tvalid && req_tready) begin
            pending_values.insert(pending_values.size(),
                                  pinned_valid ? pinned_value
                                               : decode_value(req_tdata, req_tuser));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = $signed(rsp_tdata[21:0]);
            if (pending_values.size() == 0) begin
               $display("%0t ns: unexpected result word, expected none, got %0d",
                        $time, got);
               fail_count++;
            end else begin
               want = pending_values.pop_front();
               if (got !== want) begin
                  $display("%0t ns: value mismatch, expected %0d, got %0d",
                           $time, want, got);
                  fail_count++;
               end
            end
         end
      end
   end

   // Offers one word, after random gaps, and holds it until it is taken.
   task automatic send_word(input head_data_type d, input head_user_type u,
                            input logic pin, input logic signed [21:0] pin_value);
      while (int'($urandom_range(99)) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= d;
      req_tuser    <= u;
      pinned_valid <= pin;
      pinned_value <= pin_value;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // Holds the source until every result word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_values.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Writes all three strides, then pokes the unused index.
   task automatic load_strides(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [7:0] s2);
      logic [7:0] vals [4];
      logic [1:0] regs [4];
      vals = '{s0, s1, s2, 8'($urandom)};
      regs = '{REG_STRIDE_SMALL, REG_STRIDE_MEDIUM, REG_STRIDE_LARGE, REG_UNUSED};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) begin
            @(posedge clock);
         end
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random words, weighted toward the interpolated sigmoid range.
   task automatic send_random_words(input int count);
      head_data_type d;
      head_user_type u;
      for (int n = 0; n < count; n++) begin
         d.zero_pad = '0;
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: d.logit = 16'(int'($urandom_range(4095)) - 2048);
            6, 7:             d.logit = 16'($urandom);
            default:          d.logit = 16'(int'($urandom_range(4200)) - 2100);
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3: u.channel = 7'($urandom_range(1));
            4, 5, 6:    u.channel = 7'($urandom_range(3, 2));
            default:    u.channel = 7'($urandom_range(127, 4));
         endcase
         u.stage = 2'($urandom_range(3));
         if ($urandom_range(1) == 0) begin
            d.grid = 17'($urandom);
         end else begin
            d.grid = 17'(int'($urandom_range(65791)) - 256);
         end
         d.anchor = 18'($urandom);
         send_word(d, u, 1'b0, '0);
      end
   endtask

   // Stimulus: reset, directed table, then three randomized phases.
   initial begin
      head_data_type d;
      head_user_type u;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: sparse source gaps, heavy sink stalls, reset strides.
      req_idle_pct  = 7;
      rsp_stall_pct = 87;
      foreach (DIRECTED_ROWS[i]) begin
         d.zero_pad = '0;
         d.logit    = DIRECTED_ROWS[i].logit;
         d.grid     = DIRECTED_ROWS[i].grid;
         d.anchor   = DIRECTED_ROWS[i].anchor;
         u.channel  = DIRECTED_ROWS[i].channel;
         u.stage    = DIRECTED_ROWS[i].stage;
         send_word(d, u, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].value);
      end
      send_random_words(70);
      // Let the pipeline run dry once in the middle of traffic.
      drain_results();
      send_random_words(70);

      // Phase two: extreme strides, heavy source gaps, sparse stalls.
      drain_results();
      load_strides(8'd1, 8'd128, 8'd255);
      req_idle_pct  = 87;
      rsp_stall_pct = 7;
      send_random_words(140);

      // Phase three: zero and full-scale strides, no gaps or stalls.
      drain_results();
      load_strides(8'd0, 8'd255, 8'($urandom_range(128, 1)));
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_random_words(140);

      drain_results();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
